[hdl/ple_pkg.sv]
`timescale 1ns / 1ps

package ple_pkg;

   localparam int OPCODE_W   = 4;
   localparam int POSITION_W = 5;
   localparam int WORD_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int REPORT_W   = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT       = 4'd0,
      OP_PUSH_FRONT   = 4'd1,
      OP_PUSH_TAIL    = 4'd2,
      OP_REMOVE_AT    = 4'd3,
      OP_POP_FRONT    = 4'd4,
      OP_POP_BACK     = 4'd5,
      OP_REMOVE_FIRST = 4'd6,
      OP_REMOVE_ALL   = 4'd7,
      OP_FIND         = 4'd8,
      OP_COUNT        = 4'd9,
      OP_CLEAR        = 4'd10,
      OP_QUERY        = 4'd11
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_RANGE   = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_FULL    = 3'd3,
      ST_MISSING = 3'd4
   } status_type;

   // word line of a cell: keep, open a gap at k, close the gap at k
   typedef enum logic [1:0] {
      DOP_HOLD = 2'd0,
      DOP_INS  = 2'd1,
      DOP_DEL  = 2'd2
   } cell_data_op_type;

   // read line of a cell: keep, copy own word, take right neighbor
   typedef enum logic [1:0] {
      ROP_HOLD  = 2'd0,
      ROP_LOAD  = 2'd1,
      ROP_SHIFT = 2'd2
   } cell_rd_op_type;

   typedef struct packed {
      cell_data_op_type data_op;
      cell_rd_op_type   rd_op;
   } cell_cmd_type;

endpackage

[hdl/ple_if.sv]
`timescale 1ns / 1ps

interface ple_req_if;
   import ple_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OPCODE_W-1:0]          opcode;
   logic [POSITION_W-1:0]        position;
   logic signed [WORD_W-1:0]     value;

   modport source (output valid, opcode, position, value, input ready);
   modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface ple_rsp_if;
   import ple_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic signed [WORD_W-1:0]     value_out;
   logic signed [REPORT_W-1:0]   found_index;
   logic [REPORT_W-1:0]          match_count;
   logic [REPORT_W-1:0]          length;
   logic                         list_empty;

   modport source (output valid, status, value_out, found_index, match_count, length,
                   list_empty, input ready);
   modport sink   (input valid, status, value_out, found_index, match_count, length,
                   list_empty, output ready);
endinterface

[hdl/ple_cell.sv]
`timescale 1ns / 1ps

module ple_cell #(
   parameter int IDX = 0,
   parameter int IW  = 4
) (
   input  logic                          clock,
   input  ple_pkg::cell_cmd_type         cmd,
   input  logic [IW-1:0]                 k,
   input  logic [ple_pkg::WORD_W-1:0]    value,
   input  logic [ple_pkg::WORD_W-1:0]    left_data,
   input  logic [ple_pkg::WORD_W-1:0]    right_data,
   input  logic [ple_pkg::WORD_W-1:0]    right_rd,
   output logic [ple_pkg::WORD_W-1:0]    data,
   output logic [ple_pkg::WORD_W-1:0]    rd,
   output logic                          match
);
   import ple_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic [WORD_W-1:0] data_ff, data_in;
   logic [WORD_W-1:0] rd_ff, rd_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.data_op)
         DOP_INS: begin
            if (MY_IDX == k) begin
               data_in = value;
            end else if (MY_IDX > k) begin
               data_in = left_data;
            end
         end
         DOP_DEL: begin
            if (MY_IDX >= k) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_comb begin
      rd_in = rd_ff;
      case (cmd.rd_op)
         ROP_LOAD:  rd_in = data_ff;
         ROP_SHIFT: rd_in = right_rd;
         default:   rd_in = rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data  = data_ff;
   assign rd    = rd_ff;
   assign match = (data_ff == value);

endmodule

[hdl/positional_list_engine_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// req_ch    in   valid/ready          opcode, position, value
// rsp_ch    out  valid/ready          status, value_out, found_index, match_count,
//                                     length, list_empty
//
// One request is in flight at a time. Direct commands (insert, pushes, remove_at,
// pop_front, clear, query and all error cases) go from accept to the next accept
// through these steps: latch, execute in the cell row, post the response.
// Scanning commands (pop_back, remove_first, remove_all, find, count) then visit the
// cells one at a time, with up to length + 1 visits.
// Reset is synchronous and clears the length and the control state only; cell words
// are not cleared. A response waiting in the response register does not block the
// next request; a second finished result holds in the result registers, with
// req_ch.ready low, until the response register frees up.

module positional_list_engine_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   ple_req_if.sink     req_ch,
   ple_rsp_if.source   rsp_ch
);
   import ple_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POSITION_W) ? CW : POSITION_W;
   localparam logic [CW-1:0] DEPTH_V = CW'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   // Sequencer registers
   state_type               state_ff, state_in;
   logic                    done_ff, done_in;
   opcode_type              op_ff, op_in;
   logic [POSITION_W-1:0]   pos_ff, pos_in;
   logic [WORD_W-1:0]       val_ff, val_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           j_ff, j_in;

   // Result being built
   status_type              status_ff, status_in;
   logic [WORD_W-1:0]       vout_ff, vout_in;
   logic [REPORT_W-1:0]     fidx_ff, fidx_in;
   logic [CW-1:0]           mcount_ff, mcount_in;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]       rsp_vout_ff, rsp_vout_in;
   logic [REPORT_W-1:0]     rsp_fidx_ff, rsp_fidx_in;
   logic [REPORT_W-1:0]     rsp_mcount_ff, rsp_mcount_in;
   logic [REPORT_W-1:0]     rsp_length_ff, rsp_length_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   // Cell row
   cell_cmd_type            cmd;
   logic [IW-1:0]           k;
   logic [WORD_W-1:0]       data_w [DEPTH];
   logic [WORD_W-1:0]       rd_w   [DEPTH];
   logic [DEPTH-1:0]        match_w;

   logic                    accept;
   logic                    slot_free;
   logic                    is_last;
   logic [CW-1:0]           last_idx;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign last_idx  = count_ff - CW'(1);
   assign is_last   = (j_ff == last_idx);

   // Hold off new requests while a finished result still waits for the response slot.
   assign req_ch.ready = (state_ff == S_IDLE) && !done_ff;

   // Row of cells; cell 0 is the front of the list.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_w, right_w, right_rd_w;

      if (i == 0) begin : g_first
         assign left_w = val_ff;
      end else begin : g_mid_left
         assign left_w = data_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w    = '0;
         assign right_rd_w = '0;
      end else begin : g_mid_right
         assign right_w    = data_w[i+1];
         assign right_rd_w = rd_w[i+1];
      end

      ple_cell #(
         .IDX (i),
         .IW  (IW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .k          (k),
         .value      (val_ff),
         .left_data  (left_w),
         .right_data (right_w),
         .right_rd   (right_rd_w),
         .data       (data_w[i]),
         .rd         (rd_w[i]),
         .match      (match_w[i])
      );
   end

   // Sequencer: latch the request, execute it in the row, scan if needed.
   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      op_in      = op_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      count_in   = count_ff;
      j_in       = j_ff;
      status_in  = status_ff;
      vout_in    = vout_ff;
      fidx_in    = fidx_ff;
      mcount_in  = mcount_ff;
      cmd        = '{data_op: DOP_HOLD, rd_op: ROP_HOLD};
      k          = j_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            // hold the finished result until the response slot frees up
            done_in = done_ff && !slot_free;
            if (accept) begin
               op_in     = opcode_type'(req_ch.opcode);
               pos_in    = req_ch.position;
               val_in    = req_ch.value;
               status_in = ST_OK;
               vout_in   = '0;
               fidx_in   = '1;
               mcount_in = '0;
               j_in      = '0;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            // Most commands finish here; the scanning ones move on to S_SCAN.
            done_in  = 1'b1;
            state_in = S_IDLE;
            case (op_ff)
               OP_INSERT: begin
                  if (XW'(pos_ff) > XW'(count_ff)) begin
                     status_in = ST_RANGE;
                  end else if (count_ff >= DEPTH_V) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.data_op = DOP_INS;
                     k           = IW'(pos_ff);
                     count_in    = count_ff + CW'(1);
                  end
               end
               OP_PUSH_FRONT, OP_PUSH_TAIL: begin
                  if (count_ff >= DEPTH_V) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.data_op = DOP_INS;
                     k           = (op_ff == OP_PUSH_FRONT) ? '0 : count_ff[IW-1:0];
                     count_in    = count_ff + CW'(1);
                  end
               end
               OP_REMOVE_AT: begin
                  if (XW'(pos_ff) >= XW'(count_ff)) begin
                     status_in = ST_RANGE;
                  end else begin
                     cmd.data_op = DOP_DEL;
                     k           = IW'(pos_ff);
                     count_in    = count_ff - CW'(1);
                  end
               end
               OP_POP_FRONT: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     vout_in     = data_w[0];
                     cmd.data_op = DOP_DEL;
                     k           = '0;
                     count_in    = count_ff - CW'(1);
                  end
               end
               OP_POP_BACK: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     // copy the words onto the read line, then walk it to the tail
                     cmd.rd_op = ROP_LOAD;
                     done_in   = 1'b0;
                     state_in  = S_SCAN;
                  end
               end
               OP_REMOVE_FIRST, OP_REMOVE_ALL, OP_FIND: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     done_in  = 1'b0;
                     state_in = S_SCAN;
                  end
               end
               OP_COUNT: begin
                  done_in  = 1'b0;
                  state_in = S_SCAN;
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  // query and the unused codes leave the store as it is
               end
            endcase
         end

         S_SCAN: begin
            if (j_ff >= count_ff) begin
               // walked past the last word
               if (op_ff == OP_REMOVE_FIRST) begin
                  status_in = ST_MISSING;
               end
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               case (op_ff)
                  OP_POP_BACK: begin
                     if (is_last) begin
                        vout_in     = rd_w[0];
                        cmd.data_op = DOP_DEL;
                        count_in    = count_ff - CW'(1);
                        done_in     = 1'b1;
                        state_in    = S_IDLE;
                     end else begin
                        cmd.rd_op = ROP_SHIFT;
                        j_in      = j_ff + CW'(1);
                     end
                  end
                  OP_REMOVE_FIRST: begin
                     if (match_w[j_ff[IW-1:0]]) begin
                        cmd.data_op = DOP_DEL;
                        count_in    = count_ff - CW'(1);
                        done_in     = 1'b1;
                        state_in    = S_IDLE;
                     end else begin
                        j_in = j_ff + CW'(1);
                     end
                  end
                  OP_REMOVE_ALL: begin
                     // drop a match and look at the same slot again
                     if (match_w[j_ff[IW-1:0]]) begin
                        cmd.data_op = DOP_DEL;
                        count_in    = count_ff - CW'(1);
                        mcount_in   = mcount_ff + CW'(1);
                     end else begin
                        j_in = j_ff + CW'(1);
                     end
                  end
                  OP_FIND: begin
                     if (match_w[j_ff[IW-1:0]]) begin
                        fidx_in  = REPORT_W'(j_ff);
                        done_in  = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        j_in = j_ff + CW'(1);
                     end
                  end
                  default: begin
                     // count
                     if (match_w[j_ff[IW-1:0]]) begin
                        mcount_in = mcount_ff + CW'(1);
                     end
                     j_in = j_ff + CW'(1);
                  end
               endcase
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Response register: load when the command completes, hold until taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_vout_in   = rsp_vout_ff;
      rsp_fidx_in   = rsp_fidx_ff;
      rsp_mcount_in = rsp_mcount_ff;
      rsp_length_in = rsp_length_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_ff && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_vout_in   = vout_ff;
         rsp_fidx_in   = fidx_ff;
         rsp_mcount_in = REPORT_W'(mcount_ff);
         rsp_length_in = REPORT_W'(count_ff);
         rsp_empty_in  = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      j_ff          <= j_in;
      status_ff     <= status_in;
      vout_ff       <= vout_in;
      fidx_ff       <= fidx_in;
      mcount_ff     <= mcount_in;
      rsp_status_ff <= rsp_status_in;
      rsp_vout_ff   <= rsp_vout_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_mcount_ff <= rsp_mcount_in;
      rsp_length_ff <= rsp_length_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.value_out   = rsp_vout_ff;
   assign rsp_ch.found_index = rsp_fidx_ff;
   assign rsp_ch.match_count = rsp_mcount_ff;
   assign rsp_ch.length      = rsp_length_ff;
   assign rsp_ch.list_empty  = rsp_empty_ff;

endmodule

[bench/ple_list_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the list and checks every response
// against the oldest outstanding prediction.
module ple_list_checker #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   ple_req_if   req_mon,
   ple_rsp_if   rsp_mon,
   output int   failures,
   output int   pending,
   output int   list_length
);
   import ple_pkg::*;

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      status_type                 status;
      logic signed [WORD_W-1:0]   value_out;
      logic signed [REPORT_W-1:0] found_index;
      logic [REPORT_W-1:0]        match_count;
      logic [REPORT_W-1:0]        length;
      logic                       list_empty;
   } list_result_type;

   logic [WORD_W-1:0] words [DEPTH];
   int unsigned       word_count = 0;
   list_result_type   expected_results [$];
   list_result_type   oldest;

   initial begin
      failures    = 0;
      pending     = 0;
      list_length = 0;
   end

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      failures++;
      // keep the log short once a broken block floods it
      if (failures <= PRINT_LIMIT)
         $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   function automatic int unsigned first_index(input logic [WORD_W-1:0] val);
      for (int unsigned i = 0; i < word_count; i++)
         if (words[i] == val)
            return i;
      return word_count;
   endfunction

   function automatic void close_slot(input int unsigned at);
      for (int unsigned i = at; i + 1 < word_count; i++)
         words[i] = words[i + 1];
      word_count--;
   endfunction

   function automatic list_result_type apply_command(input logic [OPCODE_W-1:0] op,
                                                     input logic [POSITION_W-1:0] pos,
                                                     input logic [WORD_W-1:0] val);
      list_result_type res;
      int unsigned     k;
      int unsigned     hits;
      res.status      = ST_OK;
      res.value_out   = '0;
      res.found_index = '1;
      res.match_count = '0;
      hits            = 0;
      case (op)
         OP_INSERT, OP_PUSH_FRONT, OP_PUSH_TAIL: begin
            k = (op == OP_INSERT) ? pos : (op == OP_PUSH_FRONT) ? 0 : word_count;
            if (op == OP_INSERT && pos > word_count) begin
               res.status = ST_RANGE;
            end else if (word_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int unsigned i = word_count; i > k; i--)
                  words[i] = words[i - 1];
               words[k] = val;
               word_count++;
            end
         end
         OP_REMOVE_AT: begin
            if (pos >= word_count)
               res.status = ST_RANGE;
            else
               close_slot(pos);
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (word_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               k = (op == OP_POP_FRONT) ? 0 : word_count - 1;
               res.value_out = words[k];
               close_slot(k);
            end
         end
         OP_REMOVE_FIRST: begin
            if (word_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               k = first_index(val);
               if (k >= word_count)
                  res.status = ST_MISSING;
               else
                  close_slot(k);
            end
         end
         OP_REMOVE_ALL: begin
            if (word_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               k = 0;
               for (int unsigned i = 0; i < word_count; i++) begin
                  if (words[i] == val) begin
                     hits++;
                  end else begin
                     words[k] = words[i];
                     k++;
                  end
               end
               word_count      = k;
               res.match_count = REPORT_W'(hits);
            end
         end
         OP_FIND: begin
            if (word_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               k = first_index(val);
               if (k < word_count)
                  res.found_index = REPORT_W'(k);
            end
         end
         OP_COUNT: begin
            for (int unsigned i = 0; i < word_count; i++)
               if (words[i] == val)
                  hits++;
            res.match_count = REPORT_W'(hits);
         end
         OP_CLEAR: word_count = 0;
         default: ;
      endcase
      res.length     = REPORT_W'(word_count);
      res.list_empty = (word_count == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         word_count = 0;
         expected_results.delete();
      end else begin
         // retire the response first: it can never belong to a request taken this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", rsp_mon.status, '0);
            end else begin
               oldest = expected_results.pop_front();
               compare_field("status", rsp_mon.status, oldest.status);
               compare_field("value_out", rsp_mon.value_out, oldest.value_out);
               compare_field("found_index", rsp_mon.found_index, oldest.found_index);
               compare_field("match_count", rsp_mon.match_count, oldest.match_count);
               compare_field("length", rsp_mon.length, oldest.length);
               compare_field("list_empty", rsp_mon.list_empty, oldest.list_empty);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.insert(expected_results.size(),
                                    apply_command(req_mon.opcode, req_mon.position,
                                                  req_mon.value));
      end
      pending     = expected_results.size();
      list_length = word_count;
   end

endmodule

[bench/tb_positional_list_engine_core.sv]
`timescale 1ns / 1ps

// Drives list commands into the engine and delivers the verdict; all prediction and
// response checking happens in the checker instance beside the block.
module tb_positional_list_engine_core;
   import ple_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_ITEMS   = 825;
   localparam int STALL_PERCENT  = 21;
   localparam int HOLD_CYCLES    = 120;
   localparam int TAIL_CYCLES    = 2 * (DEPTH + 4);
   localparam int WATCHDOG_LIMIT = 2000;
   // opcodes above OP_QUERY are unassigned; the engine answers them as a query
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST = 4'd15;

   // growth phases favor adds, drain phases favor removals, mixed takes anything
   localparam int PHASE_GROW  = 0;
   localparam int PHASE_DRAIN = 1;
   localparam int PHASE_MIXED = 2;

   logic clock;
   logic reset;

   ple_req_if req_ch ();
   ple_rsp_if rsp_ch ();

   int mismatches;
   int in_flight;
   int model_length;

   // Stall control shared by both sides; hold_request starts the long receiver hold.
   bit stalls_on    = 1'b1;
   bit hold_request = 1'b0;

   positional_list_engine_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   ple_list_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .failures   (mismatches),
      .pending    (in_flight),
      .list_length(model_length)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response side: drop ready at random, or hold it low for a long stretch on demand
   // so the engine backs up and stops taking requests.
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = !stalls_on || ($urandom_range(99) >= STALL_PERCENT);
         end
      end
   end

   // Watchdog: end the run once nothing has moved on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      wait (reset === 1'b0);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Present one request from a falling edge and hold it until accepted; return on the
   // falling edge after the accept so the next call can either idle or follow at once.
   task automatic send_command(input logic [OPCODE_W-1:0] op,
                               input logic [POSITION_W-1:0] pos,
                               input logic [WORD_W-1:0] val);
      while (stalls_on && $urandom_range(99) < STALL_PERCENT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.opcode   = op;
      req_ch.position = pos;
      req_ch.value    = val;
      do
         @(posedge clock);
      while (!req_ch.ready);
      @(negedge clock);
   endtask

   initial begin
      int                    phase;
      int                    pick;
      logic [OPCODE_W-1:0]   op;
      logic [POSITION_W-1:0] pos;
      logic [WORD_W-1:0]     val;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = OP_QUERY;
      req_ch.position = '0;
      req_ch.value    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: the lookups, removals and an out-of-range insert on an empty list first,
      // then a small list with extreme words and duplicates.
      send_command(OP_QUERY, '0, 0);
      send_command(OP_POP_FRONT, '0, 0);
      send_command(OP_POP_BACK, '0, 0);
      send_command(OP_REMOVE_AT, '0, 0);
      send_command(OP_REMOVE_FIRST, '0, 7);
      send_command(OP_REMOVE_ALL, '0, 7);
      send_command(OP_FIND, '0, 7);
      send_command(OP_COUNT, '0, 7);
      send_command(OP_INSERT, 5'd1, 9);               // past the end of an empty list
      send_command(OP_INSERT, '0, 32'h8000_0000);
      send_command(OP_PUSH_TAIL, '0, 32'h7FFF_FFFF);
      send_command(OP_PUSH_FRONT, '0, 0);
      send_command(OP_INSERT, 5'd3, 32'hFFFF_FFFF);   // position equal to length appends
      send_command(OP_INSERT, 5'd1, 0);
      send_command(OP_FIND, '0, 32'hFFFF_FFFF);
      send_command(OP_FIND, '0, 123);                 // absent word
      send_command(OP_COUNT, '0, 0);
      send_command(OP_REMOVE_FIRST, '0, 123);         // nothing to remove
      send_command(OP_REMOVE_ALL, '0, 0);
      send_command(OP_REMOVE_AT, 5'd3, 0);            // just past the last word
      send_command(OP_REMOVE_AT, 5'd1, 0);
      send_command(OP_POP_BACK, '0, 0);
      send_command(OP_POP_FRONT, '0, 0);
      send_command(OP_UNUSED_LAST, 5'd31, 32'h5A5A_A5A5);
      send_command(OP_CLEAR, '0, 0);

      // Fill past capacity with random words so the full-store answers show up early.
      for (int n = 0; n < DEPTH + 3; n++) begin
         pick = $urandom_range(0, 2);
         op   = (pick == 0) ? OP_INSERT : (pick == 1) ? OP_PUSH_FRONT : OP_PUSH_TAIL;
         send_command(op, POSITION_W'($urandom_range(0, model_length)), $urandom());
      end

      phase = PHASE_MIXED;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            phase = $urandom_range(PHASE_GROW, PHASE_MIXED);
         // run a long stretch with no stalls on either side
         stalls_on = !(n >= 400 && n < 560);
         // start the long response hold while requests keep coming
         if (n == 200 || n == 650)
            hold_request = 1'b1;

         pick = $urandom_range(0, 99);
         op   = OPCODE_W'($urandom_range(OP_INSERT, OP_QUERY));
         case (phase)
            PHASE_GROW: begin
               if (pick < 25)
                  op = OP_INSERT;
               else if (pick < 45)
                  op = OP_PUSH_FRONT;
               else if (pick < 70)
                  op = OP_PUSH_TAIL;
            end
            PHASE_DRAIN: begin
               if (pick < 15)
                  op = OP_REMOVE_AT;
               else if (pick < 35)
                  op = OP_POP_FRONT;
               else if (pick < 55)
                  op = OP_POP_BACK;
               else if (pick < 65)
                  op = OP_REMOVE_FIRST;
               else if (pick < 72)
                  op = OP_REMOVE_ALL;
            end
            default: ;
         endcase
         // keep clears rare so the list gets deep
         if (op == OP_CLEAR && $urandom_range(0, 3) != 0)
            op = OP_FIND;
         if ($urandom_range(0, 49) == 0)
            op = OPCODE_W'($urandom_range(OP_QUERY + 1, OP_UNUSED_LAST));

         // mostly legal positions for the current length; now and then any encoding
         if ($urandom_range(0, 9) == 0)
            pos = POSITION_W'($urandom());
         else
            pos = POSITION_W'($urandom_range(0, model_length));

         // a small pool of words makes matches and duplicates common
         case ($urandom_range(0, 9))
            0: val = '0;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'h8000_0000;
            3: val = 32'h7FFF_FFFF;
            4, 5, 6: val = $urandom_range(1, 6);
            default: val = $urandom();
         endcase

         send_command(op, pos, val);
      end
      req_ch.valid = 1'b0;
      stalls_on    = 1'b1;

      // drain every outstanding response, then give the engine time to misbehave
      while (in_flight != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
